// File: rtl/swdh_pkg.sv
`timescale 1ns / 1ps

package swdh_pkg;

    // Width of the retry limit register and its value after reset.
    localparam int unsigned RETRY_W     = 7;
    localparam logic [RETRY_W-1:0] RETRY_RESET = 7'd100;
    localparam logic [RETRY_W-1:0] ATTEMPT_MAX = 7'd127;

    // The request bit that marks a read transfer.
    localparam int unsigned READ_BIT = 2;

    // Acknowledge code that asks the host to try again.
    localparam logic [2:0] ACK_WAIT = 3'd2;
    localparam logic [2:0] ACK_OK   = 3'd1;

    // Status codes reported with a finished transfer.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_ACK_ERR = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;

    typedef struct packed {
        logic        line_out;
        logic        line_drive;
        logic        busy_res;
        logic        done_res;
        logic [2:0]  ack_code;
        logic [31:0] read_data;
        logic        parity_ok;
        logic [1:0]  status;
    } t_result;

endpackage

// File: rtl/swdh_core.sv
`timescale 1ns / 1ps

module swdh_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic                            i_action,
    input  logic [7:0]                      i_request,
    input  logic [31:0]                     i_write_data,
    input  logic                            i_line_in,
    input  logic                            i_cfg_we,
    input  logic [swdh_pkg::RETRY_W-1:0]    i_cfg_data,
    output swdh_pkg::t_result               o_result
);
    import swdh_pkg::*;

    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_REQ       = 4'd1;
    localparam logic [3:0] PH_TRN_IN    = 4'd2;
    localparam logic [3:0] PH_ACK       = 4'd3;
    localparam logic [3:0] PH_TRN_RETRY = 4'd4;
    localparam logic [3:0] PH_RDATA     = 4'd5;
    localparam logic [3:0] PH_RPAR      = 4'd6;
    localparam logic [3:0] PH_TRN_END   = 4'd7;
    localparam logic [3:0] PH_TRN_PRE   = 4'd8;
    localparam logic [3:0] PH_WDATA     = 4'd9;
    localparam logic [3:0] PH_WPAR      = 4'd10;

    logic [RETRY_W-1:0] r_retry_limit;
    logic [3:0]         r_phase,   n_phase;
    logic [5:0]         r_bit_idx, n_bit_idx;
    logic [RETRY_W-1:0] r_attempt, n_attempt;
    logic [7:0]         r_request, n_request;
    logic [31:0]        r_shift,   n_shift;
    logic [2:0]         r_ack,     n_ack;
    logic               r_parity,  n_parity;

    logic [RETRY_W-1:0] limit;
    logic [2:0]         ack_new;
    logic               is_read;
    logic               lout, drive, done, pok;
    logic [31:0]        rdata;
    logic [1:0]         status;

    assign limit   = (r_retry_limit == '0) ? RETRY_W'(1) : r_retry_limit;
    assign is_read = r_request[READ_BIT];
    assign ack_new = r_ack | (3'({2'b00, i_line_in} << r_bit_idx[1:0]));

    always_comb begin
        n_phase   = r_phase;
        n_bit_idx = r_bit_idx;
        n_attempt = r_attempt;
        n_request = r_request;
        n_shift   = r_shift;
        n_ack     = r_ack;
        n_parity  = r_parity;
        lout      = 1'b0;
        drive     = 1'b0;
        done      = 1'b0;
        pok       = 1'b0;
        rdata     = '0;
        status    = STATUS_OK;

        if (i_action) begin
            if (r_phase == PH_IDLE) begin
                if (i_request == 8'd0) begin
                    done   = 1'b1;
                    status = STATUS_INVALID;
                end else begin
                    n_request = i_request;
                    n_shift   = i_write_data;
                    n_attempt = '0;
                    n_bit_idx = '0;
                    n_parity  = 1'b0;
                    n_phase   = PH_REQ;
                end
            end
        end else begin
            case (r_phase)
                PH_IDLE: begin
                end
                PH_REQ: begin
                    drive     = 1'b1;
                    lout      = r_request[r_bit_idx[2:0]];
                    n_bit_idx = r_bit_idx + 6'd1;
                    if (r_bit_idx == 6'd7) begin
                        n_bit_idx = '0;
                        n_phase   = PH_TRN_IN;
                    end
                end
                PH_TRN_IN: begin
                    n_phase   = PH_ACK;
                    n_bit_idx = '0;
                    n_ack     = '0;
                end
                PH_ACK: begin
                    n_ack     = ack_new;
                    n_bit_idx = r_bit_idx + 6'd1;
                    if (r_bit_idx >= 6'd2) begin
                        n_bit_idx = '0;
                        if (r_attempt < ATTEMPT_MAX) begin
                            n_attempt = r_attempt + RETRY_W'(1);
                        end
                        if (ack_new == ACK_WAIT) begin
                            n_phase = PH_TRN_RETRY;
                        end else if (is_read) begin
                            n_phase  = PH_RDATA;
                            n_shift  = '0;
                            n_parity = 1'b0;
                        end else begin
                            n_phase = PH_TRN_PRE;
                        end
                    end
                end
                PH_TRN_RETRY: begin
                    drive = 1'b1;
                    n_bit_idx = '0;
                    if (r_attempt < limit) begin
                        n_phase = PH_REQ;
                    end else if (is_read) begin
                        n_phase  = PH_RDATA;
                        n_shift  = '0;
                        n_parity = 1'b0;
                    end else begin
                        n_phase = PH_TRN_PRE;
                    end
                end
                PH_RDATA: begin
                    n_shift   = {i_line_in, r_shift[31:1]};
                    n_parity  = r_parity ^ i_line_in;
                    n_bit_idx = r_bit_idx + 6'd1;
                    if (r_bit_idx >= 6'd31) begin
                        n_bit_idx = '0;
                        n_phase   = PH_RPAR;
                    end
                end
                PH_RPAR: begin
                    n_parity = r_parity ^ i_line_in;
                    n_phase  = PH_TRN_END;
                end
                PH_TRN_END: begin
                    drive   = 1'b1;
                    done    = 1'b1;
                    rdata   = r_shift;
                    pok     = ~r_parity;
                    status  = (r_ack > ACK_OK) ? STATUS_ACK_ERR : STATUS_OK;
                    n_phase = PH_IDLE;
                end
                PH_TRN_PRE: begin
                    drive     = 1'b1;
                    n_parity  = 1'b0;
                    n_bit_idx = '0;
                    n_phase   = PH_WDATA;
                end
                PH_WDATA: begin
                    drive     = 1'b1;
                    lout      = r_shift[0];
                    n_parity  = r_parity ^ r_shift[0];
                    n_shift   = {1'b0, r_shift[31:1]};
                    n_bit_idx = r_bit_idx + 6'd1;
                    if (r_bit_idx >= 6'd31) begin
                        n_bit_idx = '0;
                        n_phase   = PH_WPAR;
                    end
                end
                PH_WPAR: begin
                    drive   = 1'b1;
                    lout    = r_parity;
                    done    = 1'b1;
                    status  = (r_ack > ACK_OK) ? STATUS_ACK_ERR : STATUS_OK;
                    n_phase = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_result.line_out   = lout;
        o_result.line_drive = drive;
        o_result.busy_res   = (n_phase != PH_IDLE);
        o_result.done_res   = done;
        o_result.ack_code   = n_ack;
        o_result.read_data  = rdata;
        o_result.parity_ok  = pok;
        o_result.status     = status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit <= RETRY_RESET;
            r_phase       <= PH_IDLE;
            r_bit_idx     <= '0;
            r_attempt     <= '0;
            r_request     <= '0;
            r_shift       <= '0;
            r_ack         <= '0;
            r_parity      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_retry_limit <= i_cfg_data;
            end
            if (i_accept) begin
                r_phase   <= n_phase;
                r_bit_idx <= n_bit_idx;
                r_attempt <= n_attempt;
                r_request <= n_request;
                r_shift   <= n_shift;
                r_ack     <= n_ack;
                r_parity  <= n_parity;
            end
        end
    end

endmodule

// File: rtl/swdh_out_reg.sv
`timescale 1ns / 1ps

module swdh_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  swdh_pkg::t_result i_result,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic              o_busy,
    output swdh_pkg::t_result o_result
);
    import swdh_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Full and held by the consumer: nothing more may be loaded.
    assign o_busy      = r_valid & i_out_stall;
    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// File: rtl/swd_host_transfer_engine_unit.sv
`timescale 1ns / 1ps
// A result beat appears in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle, limited only by stall on the result side,
// which holds the single result register full.
// Reset (synchronous, active low): the engine returns to idle, every state
// register clears, the retry limit becomes 100 and the result register empties.

module swd_host_transfer_engine_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_action,
    input  logic [7:0]                   i_request,
    input  logic [31:0]                  i_write_data,
    input  logic                         i_line_in,
    // Result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_line_out,
    output logic                         o_line_drive,
    output logic                         o_busy_res,
    output logic                         o_done_res,
    output logic [2:0]                   o_ack_code,
    output logic [31:0]                  o_read_data,
    output logic                         o_parity_ok,
    output logic [1:0]                   o_status,
    // Retry limit register
    input  logic                         i_cfg_we,
    input  logic [swdh_pkg::RETRY_W-1:0] i_cfg_data
);
    import swdh_pkg::*;

    // An input beat is taken whenever the result register can receive its
    // result: either it is empty or its current beat leaves in this cycle.
    logic    accept;
    logic    out_full;
    t_result step_result;
    t_result held_result;

    assign o_in_stall = out_full;
    assign accept     = i_in_valid & ~out_full;

    // The protocol sequencer: the state registers plus the single-pass step
    // logic that turns one tick or start beat into one result beat.
    swdh_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_action     (i_action),
        .i_request    (i_request),
        .i_write_data (i_write_data),
        .i_line_in    (i_line_in),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_result     (step_result)
    );

    // The result register decouples the two channels, so the sequencer keeps
    // stepping while the consumer drains the previous beat.
    swdh_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_result    (step_result),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_busy      (out_full),
        .o_result    (held_result)
    );

    assign o_line_out   = held_result.line_out;
    assign o_line_drive = held_result.line_drive;
    assign o_busy_res   = held_result.busy_res;
    assign o_done_res   = held_result.done_res;
    assign o_ack_code   = held_result.ack_code;
    assign o_read_data  = held_result.read_data;
    assign o_parity_ok  = held_result.parity_ok;
    assign o_status     = held_result.status;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the serial wire debug transfer engine. The stimulus
// process offers one input beat at a time, runs its own copy of the engine on
// every beat that the block accepts, and queues the result that it predicts.
// A separate monitor pops that queue for each result beat that leaves the block.

module testbench;
    import swdh_pkg::*;

    // Action codes of an input beat.
    localparam bit ACT_TICK  = 1'b0;
    localparam bit ACT_START = 1'b1;

    // A fault answer from the target; only OK and WAIT come from the package.
    localparam logic [2:0] ACK_FAULT = 3'd4;

    // Write request with every bit set except the read bit.
    localparam logic [7:0] DIR_REQ = 8'hFB;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int REPORT_MAX  = 10;

    // Phases of a transfer as the predictor tracks them.
    typedef enum int {
        LINK_IDLE, LINK_REQ, LINK_TRN_IN, LINK_ACK, LINK_TRN_RETRY, LINK_RDATA,
        LINK_RPAR, LINK_TRN_END, LINK_TRN_PRE, LINK_WDATA, LINK_WPAR
    } t_link_phase;

    // How the target side fills the data line during a read.
    typedef enum int {DATA_RANDOM, DATA_ZEROS, DATA_ONES} t_data_mode;

    // One row of the directed table. Where lit is set, want is the result
    // typed in by hand; otherwise the predictor supplies it.
    typedef struct {
        bit          act;
        logic [7:0]  rq;
        logic [31:0] wd;
        bit          lin;
        bit          lit;
        t_result     want;
    } t_stim_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_action;
    logic [7:0]         i_request;
    logic [31:0]        i_write_data;
    logic               i_line_in;
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_line_out;
    logic               o_line_drive;
    logic               o_busy_res;
    logic               o_done_res;
    logic [2:0]         o_ack_code;
    logic [31:0]        o_read_data;
    logic               o_parity_ok;
    logic [1:0]         o_status;
    logic               i_cfg_we;
    logic [RETRY_W-1:0] i_cfg_data;

    swd_host_transfer_engine_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_request    (i_request),
        .i_write_data (i_write_data),
        .i_line_in    (i_line_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_line_out   (o_line_out),
        .o_line_drive (o_line_drive),
        .o_busy_res   (o_busy_res),
        .o_done_res   (o_done_res),
        .o_ack_code   (o_ack_code),
        .o_read_data  (o_read_data),
        .o_parity_ok  (o_parity_ok),
        .o_status     (o_status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Predictor state: a private copy of the engine's registers and of the
    // retry limit.
    t_link_phase  link_ph;
    int           link_bit;
    logic [6:0]   link_attempts;
    logic [6:0]   link_limit;
    logic [7:0]   link_req;
    logic [31:0]  link_shift;
    logic [2:0]   link_ack;
    logic         link_par;

    // Results predicted for accepted input beats, oldest first.
    t_result pending_results[$];

    // Bookkeeping shared by the processes below.
    int  burst_left;
    int  items_sent;
    int  reads_started;
    int  writes_started;
    int  wait_answers;
    int  results_checked;
    int  mismatches;
    int  cycle_count;
    bit  hold_wanted;
    bit  hold_done;

    // Copies of the block's outputs taken on the falling edge, so that the
    // decision made at the next rising edge never races the block's own update.
    logic    smp_rst;
    logic    smp_valid;
    logic    smp_stall;
    t_result smp_res;

    function automatic t_result res(bit lout, bit drive, bit busy, bit done,
                                    logic [2:0] ack, logic [31:0] rdata,
                                    bit pok, logic [1:0] st);
        t_result r;
        r.line_out   = lout;
        r.line_drive = drive;
        r.busy_res   = busy;
        r.done_res   = done;
        r.ack_code   = ack;
        r.read_data  = rdata;
        r.parity_ok  = pok;
        r.status     = st;
        return r;
    endfunction

    function automatic t_stim_row stim_row(bit act, logic [7:0] rq, logic [31:0] wd,
                                           bit lin, bit lit, t_result want);
        t_stim_row row;
        row.act  = act;
        row.rq   = rq;
        row.wd   = wd;
        row.lin  = lin;
        row.lit  = lit;
        row.want = want;
        return row;
    endfunction

    function automatic string res_text(t_result r);
        return $sformatf("out=%0b drive=%0b busy=%0b done=%0b ack=%0d data=%h pok=%0b st=%0d",
                         r.line_out, r.line_drive, r.busy_res, r.done_res, r.ack_code,
                         r.read_data, r.parity_ok, r.status);
    endfunction

    // After the last acknowledge a read clears the shift register and starts
    // sampling at once, whereas a write first hands the line back to the host.
    function automatic void start_data_phase();
        link_bit = 0;
        if (link_req[READ_BIT]) begin
            link_ph    = LINK_RDATA;
            link_shift = '0;
            link_par   = 1'b0;
        end else begin
            link_ph = LINK_TRN_PRE;
        end
    endfunction

    // Advances the predicted engine by one input beat and returns the result
    // beat that the block should give for it.
    function automatic t_result engine_step(bit act, logic [7:0] rq, logic [31:0] wd,
                                            bit lin);
        t_result    r;
        logic [6:0] lim;
        r   = '0;
        lim = (link_limit == 7'd0) ? 7'd1 : link_limit;
        if (act == ACT_START) begin
            // A start is only taken while idle; a zero request never gets going.
            if (link_ph == LINK_IDLE) begin
                if (rq == 8'h00) begin
                    r.done_res = 1'b1;
                    r.status   = STATUS_INVALID;
                end else begin
                    link_req      = rq;
                    link_shift    = wd;
                    link_attempts = '0;
                    link_bit      = 0;
                    link_par      = 1'b0;
                    link_ph       = LINK_REQ;
                end
            end
        end else begin
            case (link_ph)
                LINK_REQ: begin
                    r.line_drive = 1'b1;
                    r.line_out   = link_req[link_bit & 7];
                    link_bit++;
                    if (link_bit >= 8) begin
                        link_bit = 0;
                        link_ph  = LINK_TRN_IN;
                    end
                end
                LINK_TRN_IN: begin
                    link_ph  = LINK_ACK;
                    link_bit = 0;
                    link_ack = '0;
                end
                LINK_ACK: begin
                    link_ack[link_bit] = link_ack[link_bit] | lin;
                    link_bit++;
                    if (link_bit >= 3) begin
                        link_bit = 0;
                        if (link_attempts < ATTEMPT_MAX) begin
                            link_attempts++;
                        end
                        if (link_ack == ACK_WAIT) begin
                            link_ph = LINK_TRN_RETRY;
                        end else begin
                            start_data_phase();
                        end
                    end
                end
                LINK_TRN_RETRY: begin
                    r.line_drive = 1'b1;
                    if (link_attempts < lim) begin
                        link_ph  = LINK_REQ;
                        link_bit = 0;
                    end else begin
                        start_data_phase();
                    end
                end
                LINK_RDATA: begin
                    link_shift = {lin, link_shift[31:1]};
                    link_par   = link_par ^ lin;
                    link_bit++;
                    if (link_bit >= 32) begin
                        link_bit = 0;
                        link_ph  = LINK_RPAR;
                    end
                end
                LINK_RPAR: begin
                    link_par = link_par ^ lin;
                    link_ph  = LINK_TRN_END;
                end
                LINK_TRN_END: begin
                    r.line_drive = 1'b1;
                    r.done_res   = 1'b1;
                    r.read_data  = link_shift;
                    r.parity_ok  = (link_par == 1'b0);
                    r.status     = (link_ack > ACK_OK) ? STATUS_ACK_ERR : STATUS_OK;
                    link_ph      = LINK_IDLE;
                end
                LINK_TRN_PRE: begin
                    r.line_drive = 1'b1;
                    link_par     = 1'b0;
                    link_bit     = 0;
                    link_ph      = LINK_WDATA;
                end
                LINK_WDATA: begin
                    r.line_drive = 1'b1;
                    r.line_out   = link_shift[0];
                    link_par     = link_par ^ link_shift[0];
                    link_shift   = link_shift >> 1;
                    link_bit++;
                    if (link_bit >= 32) begin
                        link_bit = 0;
                        link_ph  = LINK_WPAR;
                    end
                end
                LINK_WPAR: begin
                    r.line_drive = 1'b1;
                    r.line_out   = link_par;
                    r.done_res   = 1'b1;
                    r.status     = (link_ack > ACK_OK) ? STATUS_ACK_ERR : STATUS_OK;
                    link_ph      = LINK_IDLE;
                end
                default: begin
                    link_ph = LINK_IDLE;
                end
            endcase
        end
        r.busy_res = (link_ph != LINK_IDLE);
        r.ack_code = link_ack;
        return r;
    endfunction

    // Chooses the target's answer for one request attempt.
    function automatic logic [2:0] pick_ack(int wait_pct, bit allow_wait);
        if (allow_wait && $urandom_range(0, 99) < wait_pct) begin
            return ACK_WAIT;
        end
        case ($urandom_range(0, 9))
            0:       return ACK_FAULT;
            1:       return 3'($urandom_range(0, 7));
            default: return ACK_OK;
        endcase
    endfunction

    // Offers one input beat and holds it until the block takes it. Bursts of
    // beats are separated by short random gaps. Once the beat has gone in,
    // the predictor is stepped and its result, or the one typed into the
    // table, is queued.
    task automatic drive_beat(bit act, logic [7:0] rq, logic [31:0] wd, bit lin,
                              bit lit, t_result want);
        int      gap;
        bit      stalled;
        t_result predicted;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_request    <= rq;
        i_write_data <= wd;
        i_line_in    <= lin;
        do begin
            @(negedge i_clk);
            stalled = o_in_stall;
            @(posedge i_clk);
        end while (stalled);
        predicted = engine_step(act, rq, wd, lin);
        pending_results.push_back(lit ? want : predicted);
    endtask

    // Clocks the current transfer through to its end. The data line is
    // chosen from the predicted phase: the acknowledge follows a plan picked
    // once per attempt, read data follows the requested pattern, and every
    // other cycle sees a random level. Now and then a start beat is slipped
    // in, which the engine has to ignore while busy.
    task automatic complete_transfer(int wait_pct, int wait_cap, t_data_mode mode);
        int         waits;
        logic [2:0] plan;
        bit         lin;
        waits = 0;
        plan  = ACK_OK;
        while (link_ph != LINK_IDLE) begin
            lin = 1'($urandom_range(0, 1));
            if (link_ph == LINK_ACK) begin
                if (link_bit == 0) begin
                    plan = pick_ack(wait_pct, waits < wait_cap);
                    if (plan == ACK_WAIT) begin
                        waits++;
                    end
                end
                lin = plan[link_bit];
            end else if (link_ph == LINK_RDATA && mode == DATA_ZEROS) begin
                lin = 1'b0;
            end else if (link_ph == LINK_RDATA && mode == DATA_ONES) begin
                lin = 1'b1;
            end
            if ($urandom_range(0, 99) < 3) begin
                drive_beat(ACT_START, 8'($urandom), $urandom, lin, 1'b0, '0);
            end else begin
                drive_beat(ACT_TICK, 8'($urandom), $urandom, lin, 1'b0, '0);
            end
            items_sent++;
        end
        wait_answers += waits;
    endtask

    // Whole transfers with random content, mixed with zero requests and idle
    // ticks, until the running beat count reaches the quota.
    task automatic random_transfers(int quota, int wait_pct, int wait_cap);
        int          pick;
        logic [7:0]  rq;
        logic [31:0] wd;
        t_data_mode  mode;
        while (items_sent < quota) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                drive_beat(ACT_START, 8'h00, $urandom, 1'($urandom_range(0, 1)), 1'b0, '0);
            end else if (pick == 1) begin
                repeat ($urandom_range(1, 3)) begin
                    drive_beat(ACT_TICK, 8'($urandom), $urandom, 1'($urandom_range(0, 1)),
                               1'b0, '0);
                end
            end
            rq = 8'($urandom_range(1, 255));
            case ($urandom_range(0, 7))
                0:       wd = '0;
                1:       wd = '1;
                default: wd = $urandom;
            endcase
            case ($urandom_range(0, 6))
                0:       mode = DATA_ZEROS;
                1:       mode = DATA_ONES;
                default: mode = DATA_RANDOM;
            endcase
            if (rq[READ_BIT]) begin
                reads_started++;
            end else begin
                writes_started++;
            end
            drive_beat(ACT_START, rq, wd, 1'($urandom_range(0, 1)), 1'b0, '0);
            items_sent++;
            complete_transfer(wait_pct, wait_cap, mode);
        end
    endtask

    // The sender stops offering and waits for every predicted result to come.
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // The retry limit is only written once the block has nothing in flight.
    task automatic set_retry_limit(logic [RETRY_W-1:0] value);
        wait_results_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        link_limit = value;
        @(posedge i_clk);
    endtask

    // Main stimulus: reset, the directed table, then random transfers under a
    // series of retry limits that includes both ends of the register.
    initial begin : stimulus
        t_stim_row rows[$];
        int        k;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_action     <= ACT_TICK;
        i_request    <= '0;
        i_write_data <= '0;
        i_line_in    <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_data   <= '0;
        link_ph       = LINK_IDLE;
        link_bit      = 0;
        link_attempts = '0;
        link_limit    = RETRY_RESET;
        link_req      = '0;
        link_shift    = '0;
        link_ack      = '0;
        link_par      = 1'b0;
        burst_left    = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A tick while idle does nothing, and a zero request ends at once as
        // invalid.
        rows.push_back(stim_row(ACT_TICK, 8'h00, 32'h0, 1'b1, 1'b1,
                                res(1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 32'h0, 1'b0, STATUS_OK)));
        rows.push_back(stim_row(ACT_START, 8'h00, 32'hFFFF_FFFF, 1'b0, 1'b1,
                                res(1'b0, 1'b0, 1'b0, 1'b1, 3'd0, 32'h0, 1'b0,
                                    STATUS_INVALID)));
        // A write of all ones starts; a second start while busy is ignored.
        rows.push_back(stim_row(ACT_START, DIR_REQ, 32'hFFFF_FFFF, 1'b1, 1'b1,
                                res(1'b0, 1'b0, 1'b1, 1'b0, 3'd0, 32'h0, 1'b0, STATUS_OK)));
        rows.push_back(stim_row(ACT_START, 8'hFF, 32'h0, 1'b0, 1'b1,
                                res(1'b0, 1'b0, 1'b1, 1'b0, 3'd0, 32'h0, 1'b0, STATUS_OK)));
        // The request goes out LSB first while the host drives the line.
        for (k = 0; k < 8; k++) begin
            rows.push_back(stim_row(ACT_TICK, k[0] ? 8'hFF : 8'h00,
                                    k[0] ? 32'hFFFF_FFFF : 32'h0, k[0], 1'b1,
                                    res(DIR_REQ[k], 1'b1, 1'b1, 1'b0, 3'd0, 32'h0, 1'b0,
                                        STATUS_OK)));
        end
        // Turnaround: the line is released for the target.
        rows.push_back(stim_row(ACT_TICK, 8'h00, 32'h0, 1'b1, 1'b1,
                                res(1'b0, 1'b0, 1'b1, 1'b0, 3'd0, 32'h0, 1'b0, STATUS_OK)));
        // The target answers WAIT, so a retry turnaround and a second request
        // attempt follow.
        for (k = 0; k < 3; k++) begin
            rows.push_back(stim_row(ACT_TICK, 8'hFF, 32'h0, ACK_WAIT[k], 1'b0, '0));
        end
        rows.push_back(stim_row(ACT_TICK, 8'h00, 32'hFFFF_FFFF, 1'b1, 1'b0, '0));
        for (k = 0; k < 8; k++) begin
            rows.push_back(stim_row(ACT_TICK, 8'($urandom), $urandom,
                                    1'($urandom_range(0, 1)), 1'b0, '0));
        end
        foreach (rows[r]) begin
            drive_beat(rows[r].act, rows[r].rq, rows[r].wd, rows[r].lin, rows[r].lit,
                       rows[r].want);
        end
        items_sent = rows.size();
        complete_transfer(20, 4, DATA_RANDOM);

        random_transfers(150, 20, 4);
        // With a limit of one, a single WAIT already exhausts the retries;
        // a limit of zero must behave in the same way.
        set_retry_limit(7'd1);
        random_transfers(300, 60, 127);
        set_retry_limit(7'd0);
        random_transfers(420, 60, 127);
        // At the top limit the receiver is asked for its long hold-off, so
        // the result register fills and the input backs up.
        set_retry_limit(ATTEMPT_MAX);
        hold_wanted = 1'b1;
        random_transfers(600, 25, 6);
        set_retry_limit(7'd3);
        random_transfers(720, 50, 127);
        set_retry_limit(7'($urandom_range(2, 126)));
        random_transfers(850, 30, 6);
        set_retry_limit(7'($urandom_range(1, 127)));
        random_transfers(950, 30, 6);

        wait_results_drained();
        repeat (4) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            mismatches++;
            $display("%0d predicted results never arrived", pending_results.size());
        end
        $display("covered %0d read and %0d write transfers with %0d WAIT answers",
                 reads_started, writes_started, wait_answers);
        $display("retry limits 100, 1, 0, 127, 3 and two random values; %0d result beats, %0d mismatches",
                 results_checked, mismatches);
        if (mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // The receiver stalls on a pattern of its own: clear stretches, coin-flip
    // stretches, regular gaps and sparse stalls. Once asked, it holds off for
    // a long run of cycles while the sender keeps offering beats.
    initial begin : result_stall_pattern
        int mode;
        int len;
        int k;
        i_out_stall <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_wanted && !hold_done) begin
                hold_done = 1'b1;
                for (k = 0; k < HOLD_CYCLES; k++) begin
                    i_out_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end
            mode = $urandom_range(0, 3);
            len  = $urandom_range(8, 64);
            for (k = 0; k < len; k++) begin
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= 1'($urandom_range(0, 1));
                    2:       i_out_stall <= (k % 3 == 2);
                    default: i_out_stall <= ($urandom_range(0, 4) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    always @(negedge i_clk) begin
        smp_rst              <= i_rst_n;
        smp_valid            <= o_out_valid;
        smp_stall            <= i_out_stall;
        smp_res.line_out     <= o_line_out;
        smp_res.line_drive   <= o_line_drive;
        smp_res.busy_res     <= o_busy_res;
        smp_res.done_res     <= o_done_res;
        smp_res.ack_code     <= o_ack_code;
        smp_res.read_data    <= o_read_data;
        smp_res.parity_ok    <= o_parity_ok;
        smp_res.status       <= o_status;
    end

    // Every result beat taken at this edge is compared with the oldest
    // prediction; only the first few mismatches are printed in full.
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (smp_rst === 1'b1 && smp_valid === 1'b1 && smp_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("result beat with nothing predicted: %s", res_text(smp_res));
                end
            end else begin
                want = pending_results.pop_front();
                if (smp_res !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("result beat %0d differs", results_checked);
                        $display("  expected %s", res_text(want));
                        $display("  actual   %s", res_text(smp_res));
                    end
                end
            end
            results_checked++;
        end
    end

    // Guard against a hang anywhere in the run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles with %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("testbench NOT OK");
            $finish;
        end
    end

endmodule
